@@ hdl/pdc_pkg.sv @@
// shared constants, coefficient tables and item type for the sphere drag coefficient block
// no dependencies
`timescale 1ns / 1ps

package pdc_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int RE_W       = 32;
    localparam int OUT_W      = 32;
    localparam int NUM_RANGES = 8;
    localparam int RANGE_W    = 3;
    localparam int A_W        = 26;
    localparam int B_W        = 38;
    localparam int C_W        = 16;
    localparam int SCALE      = 10000;
    localparam int SCALE_W    = 14;
    localparam int SQ_W       = 2 * RE_W;
    localparam int HALF_W     = RE_W;
    localparam int AR_W       = A_W + RE_W + 1;
    localparam int CRR_W      = C_W + SQ_W;
    localparam int DEN_W      = SCALE_W + SQ_W;
    localparam int NUM_W      = 3 * FRAC_BITS + 62;
    localparam int CMP_W      = ((NUM_W > DEN_W + OUT_W) ? NUM_W : DEN_W + OUT_W) + 1;
    localparam int TEN_W      = RE_W + 24;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;
    localparam int DIV_STAGES = OUT_W;

    // upper bound of each range in tenths of Re
    function automatic logic [TEN_W-1:0] bound_tenths(input int idx);
        logic [TEN_W-1:0] b;
        begin
            case (idx)
                0:       b = TEN_W'(1);
                1:       b = TEN_W'(10);
                2:       b = TEN_W'(100);
                3:       b = TEN_W'(1000);
                4:       b = TEN_W'(10000);
                5:       b = TEN_W'(50000);
                default: b = TEN_W'(100000);
            endcase
            return b << FRAC_BITS;
        end
    endfunction

    // coefficients scaled by 10^4
    function automatic logic signed [A_W-1:0] coef_a(input logic [RANGE_W-1:0] k);
        logic signed [A_W-1:0] v;
        begin
            case (k)
                3'd0:    v = A_W'(240000);
                3'd1:    v = A_W'(227300);
                3'd2:    v = A_W'(291667);
                3'd3:    v = A_W'(465000);
                3'd4:    v = A_W'(983300);
                3'd5:    v = A_W'(1486200);
                3'd6:    v = -A_W'(4905460);
                default: v = -A_W'(16625000);
            endcase
            return v;
        end
    endfunction

    function automatic logic signed [B_W-1:0] coef_b(input logic [RANGE_W-1:0] k);
        logic signed [B_W-1:0] v;
        begin
            case (k)
                3'd0:    v = B_W'(0);
                3'd1:    v = B_W'(903);
                3'd2:    v = -B_W'(38889);
                3'd3:    v = -B_W'(1166700);
                3'd4:    v = -B_W'(27780000);
                3'd5:    v = -B_W'(475000000);
                3'd6:    v = B_W'(64'd5787000000);
                default: v = B_W'(64'd54167000000);
            endcase
            return v;
        end
    endfunction

    function automatic logic [C_W-1:0] coef_c(input logic [RANGE_W-1:0] k);
        logic [C_W-1:0] v;
        begin
            case (k)
                3'd0:    v = C_W'(0);
                3'd1:    v = C_W'(36900);
                3'd2:    v = C_W'(12220);
                3'd3:    v = C_W'(6167);
                3'd4:    v = C_W'(3644);
                3'd5:    v = C_W'(3570);
                3'd6:    v = C_W'(4600);
                default: v = C_W'(5191);
            endcase
            return v;
        end
    endfunction

    // numerator and denominator of one item, handed from front to back
    typedef struct packed {
        logic signed [NUM_W-1:0] num;
        logic [DEN_W-1:0]        den;
        logic                    zero;
    } work_t;

endpackage

@@ hdl/pdc_front.sv @@
// front pipeline: range select, products and numerator/denominator assembly
// depends on pdc_pkg
`timescale 1ns / 1ps

module pdc_front
    import pdc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [RE_W-1:0]   reynolds,
    input  logic              reynolds_valid,
    output logic              reynolds_ready,
    output logic              work_valid,
    output work_t             work,
    input  logic              work_ready
);

    logic                     adv;
    logic [3:0]               v_reg;
    logic [TEN_W-1:0]         ten_r;
    logic [RANGE_W-1:0]       k0;

    logic [SQ_W-1:0]          sq1_reg;
    logic signed [AR_W-1:0]   ar1_reg;
    logic [RANGE_W-1:0]       k1_reg;
    logic                     zero1_reg;

    logic [HALF_W+C_W-1:0]    crl2_reg, crh2_reg;
    logic [HALF_W+SCALE_W-1:0] dl2_reg, dh2_reg;
    logic signed [AR_W-1:0]   ar2_reg;
    logic [RANGE_W-1:0]       k2_reg;
    logic                     zero2_reg;

    logic [CRR_W-1:0]         crr3_reg;
    logic [DEN_W-1:0]         den3_reg;
    logic signed [AR_W-1:0]   ar3_reg;
    logic [RANGE_W-1:0]       k3_reg;
    logic                     zero3_reg;

    work_t                    w4_reg;
    logic signed [NUM_W-1:0]  num_next;

    assign adv            = !v_reg[3] || work_ready;
    assign reynolds_ready = adv;
    assign work_valid     = v_reg[3];
    assign work           = w4_reg;

    // range index is the count of bounds at or below the input
    always_comb
    begin
        ten_r = TEN_W'(reynolds) * TEN_W'(10);
        k0    = '0;
        for (int i = 0; i < NUM_RANGES - 1; i++)
        begin
            if (ten_r >= bound_tenths(i))
            begin
                k0 = k0 + RANGE_W'(1);
            end
        end
    end

    always_comb
    begin
        num_next = (NUM_W'(ar3_reg) <<< (2 * FRAC_BITS))
                 + (NUM_W'(coef_b(k3_reg)) <<< (3 * FRAC_BITS))
                 + $signed(NUM_W'(crr3_reg) << FRAC_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[2:0], reynolds_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq1_reg   <= SQ_W'(reynolds) * SQ_W'(reynolds);
            ar1_reg   <= coef_a(k0) * $signed({1'b0, reynolds});
            k1_reg    <= k0;
            zero1_reg <= (reynolds == '0);

            crl2_reg  <= coef_c(k1_reg) * sq1_reg[HALF_W-1:0];
            crh2_reg  <= coef_c(k1_reg) * sq1_reg[SQ_W-1:HALF_W];
            dl2_reg   <= SCALE_W'(SCALE) * sq1_reg[HALF_W-1:0];
            dh2_reg   <= SCALE_W'(SCALE) * sq1_reg[SQ_W-1:HALF_W];
            ar2_reg   <= ar1_reg;
            k2_reg    <= k1_reg;
            zero2_reg <= zero1_reg;

            crr3_reg  <= (CRR_W'(crh2_reg) << HALF_W) + CRR_W'(crl2_reg);
            den3_reg  <= (DEN_W'(dh2_reg) << HALF_W) + DEN_W'(dl2_reg);
            ar3_reg   <= ar2_reg;
            k3_reg    <= k2_reg;
            zero3_reg <= zero2_reg;

            w4_reg.num  <= num_next;
            w4_reg.den  <= den3_reg;
            w4_reg.zero <= zero3_reg;
        end
    end

endmodule

@@ hdl/pdc_queue.sv @@
// short item queue between the front and back pipelines
// depends on pdc_pkg
`timescale 1ns / 1ps

module pdc_queue
    import pdc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_valid,
    input  work_t wr_data,
    output logic  wr_ready,
    output logic  rd_valid,
    output work_t rd_data,
    input  logic  rd_ready
);

    work_t              mem [QDEPTH];
    logic [QPTR_W-1:0]  wptr_reg, rptr_reg;
    logic [QPTR_W:0]    count_reg;
    logic               push, pop;

    assign wr_ready = (count_reg != (QPTR_W+1)'(QDEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (QPTR_W+1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (QPTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= wr_data;
        end
    end

endmodule

@@ hdl/pdc_back.sv @@
// back pipeline: range check and one-bit-per-stage restoring division
// depends on pdc_pkg
`timescale 1ns / 1ps

module pdc_back
    import pdc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              work_valid,
    input  work_t             work,
    output logic              work_ready,
    output logic [OUT_W-1:0]  drag_coeff,
    output logic              saturated,
    output logic              result_valid,
    input  logic              result_ready
);

    logic                    adv;
    logic                    v_reg   [DIV_STAGES+1];
    logic [NUM_W-1:0]        rem_reg [DIV_STAGES+1];
    logic [DEN_W-1:0]        den_reg [DIV_STAGES+1];
    logic [OUT_W-1:0]        quo_reg [DIV_STAGES+1];
    logic                    sat_reg [DIV_STAGES+1];
    logic                    neg_reg [DIV_STAGES+1];

    logic [NUM_W-1:0]        rem_next [DIV_STAGES+1];
    logic [OUT_W-1:0]        quo_next [DIV_STAGES+1];
    logic [CMP_W-1:0]        dsh;
    logic                    neg0, over0;

    assign adv          = !v_reg[DIV_STAGES] || result_ready;
    assign work_ready   = adv;
    assign result_valid = v_reg[DIV_STAGES];

    // quotient above range when num >= den * 2^32
    assign neg0  = work.num[NUM_W-1];
    assign over0 = !neg0 && (CMP_W'(work.num) >= (CMP_W'(work.den) << OUT_W));

    always_comb
    begin
        rem_next[0] = work.num;
        quo_next[0] = '0;
        dsh         = '0;
        for (int j = 1; j <= DIV_STAGES; j++)
        begin
            dsh         = CMP_W'(den_reg[j-1]) << (OUT_W - j);
            rem_next[j] = rem_reg[j-1];
            quo_next[j] = quo_reg[j-1];
            if (CMP_W'(rem_reg[j-1]) >= dsh)
            begin
                rem_next[j] = NUM_W'(CMP_W'(rem_reg[j-1]) - dsh);
                quo_next[j][OUT_W - j] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= DIV_STAGES; j++)
            begin
                v_reg[j] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v_reg[0] <= work_valid;
            for (int j = 1; j <= DIV_STAGES; j++)
            begin
                v_reg[j] <= v_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= rem_next[0];
            quo_reg[0] <= quo_next[0];
            den_reg[0] <= work.den;
            sat_reg[0] <= work.zero || over0;
            neg_reg[0] <= neg0 && !work.zero;
            for (int j = 1; j <= DIV_STAGES; j++)
            begin
                rem_reg[j] <= rem_next[j];
                quo_reg[j] <= quo_next[j];
                den_reg[j] <= den_reg[j-1];
                sat_reg[j] <= sat_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
            end
        end
    end

    always_comb
    begin
        saturated = sat_reg[DIV_STAGES];
        if (sat_reg[DIV_STAGES])
        begin
            drag_coeff = '1;
        end
        else if (neg_reg[DIV_STAGES])
        begin
            drag_coeff = '0;
        end
        else
        begin
            drag_coeff = quo_reg[DIV_STAGES];
        end
    end

endmodule

@@ hdl/piecewise_sphere_drag_coefficient.sv @@
// Sphere drag coefficient from a particle Reynolds number, unsigned Q16.16 in and out.
// Takes one item per cycle when the result side keeps up; it has 4 front stages, the
// queue, and 33 back stages, set by the one-quotient-bit-per-stage divider. A 4-item queue
// lets the front keep accepting while the result side stalls, until it fills. Zero input
// or an oversized result gives all ones with saturated set; a negative result gives zero.
// depends on pdc_pkg, pdc_front, pdc_queue, pdc_back
`timescale 1ns / 1ps

module piecewise_sphere_drag_coefficient
    import pdc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [RE_W-1:0]   reynolds,
    input  logic              reynolds_valid,
    output logic              reynolds_ready,
    output logic [OUT_W-1:0]  drag_coeff,
    output logic              saturated,
    output logic              result_valid,
    input  logic              result_ready
);

    logic  fq_valid, fq_ready, qb_valid, qb_ready;
    work_t fq_data, qb_data;

    pdc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .reynolds       (reynolds),
        .reynolds_valid (reynolds_valid),
        .reynolds_ready (reynolds_ready),
        .work_valid     (fq_valid),
        .work           (fq_data),
        .work_ready     (fq_ready)
    );

    pdc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_data  (fq_data),
        .wr_ready (fq_ready),
        .rd_valid (qb_valid),
        .rd_data  (qb_data),
        .rd_ready (qb_ready)
    );

    pdc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .work_valid   (qb_valid),
        .work         (qb_data),
        .work_ready   (qb_ready),
        .drag_coeff   (drag_coeff),
        .saturated    (saturated),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule

@@ hdl/pdc_checker.sv @@
// port-level checks for the sphere drag coefficient block, bound to the top level
// depends on pdc_pkg
`timescale 1ns / 1ps

module pdc_checker
    import pdc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic [OUT_W-1:0]  drag_coeff,
    input logic              saturated,
    input logic              result_valid,
    input logic              result_ready
);

    // a stalled result item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(drag_coeff)
            && $stable(saturated))
        else $error("result item changed while stalled");

    // saturation always shows as the largest code
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && saturated |-> drag_coeff == '1)
        else $error("saturated item without full-scale value");

    // clamped zero never carries the flag
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && drag_coeff == '0 |-> !saturated)
        else $error("zero result flagged as saturated");

endmodule

bind piecewise_sphere_drag_coefficient pdc_checker u_pdc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .drag_coeff   (drag_coeff),
    .saturated    (saturated),
    .result_valid (result_valid),
    .result_ready (result_ready)
);
